// File: rtl/core/srsd_pkg.sv
`default_nettype none

package srsd_pkg;

  localparam int CHANNELS_DEF = 3;
  localparam int CHANNELS_MAX = 16;

  localparam int ACT_W   = 2;
  localparam int CH_W    = 2;
  localparam int RAW_W   = 10;
  localparam int RD_W    = 8;
  localparam int PCT_W   = 7;
  localparam int LIM_W   = 8;
  localparam int NUM_W   = 15;
  localparam int CNT_W   = 3;

  localparam int IN_DATA_W  = 16;
  localparam int IN_USER_W  = 2;
  localparam int OUT_DATA_W = 32;

  localparam logic [ACT_W-1:0] ACT_MEASURE    = 2'd0;
  localparam logic [ACT_W-1:0] ACT_CAL_START  = 2'd1;
  localparam logic [ACT_W-1:0] ACT_CAL_SAMPLE = 2'd2;

  localparam logic [PCT_W-1:0] DEADBAND_RST = 7'd2;
  localparam logic [PCT_W-1:0] PCT_FULL     = 7'd100;
  localparam logic [LIM_W-1:0] LIM_TOP      = 8'd255;
  localparam logic [LIM_W-1:0] LIM_BOT      = 8'd0;

  localparam logic [NUM_W-1:0] MUL_PCT   = 15'd100;
  localparam logic [NUM_W-1:0] MUL_OVER  = 15'd101;
  localparam logic [CNT_W-1:0] DIV_STEPS = 3'd7;

  typedef struct packed {
    logic busy;
    logic done;
  } div_sts_t;

endpackage

`default_nettype wire

// File: rtl/core/srsd_div.sv
`default_nettype none

module srsd_div (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         start,
  input  wire logic [srsd_pkg::NUM_W-1:0]   num,
  input  wire logic [srsd_pkg::LIM_W-1:0]   den,
  output srsd_pkg::div_sts_t                sts,
  output logic      [srsd_pkg::PCT_W-1:0]   quo
);
  import srsd_pkg::*;

  logic [NUM_W-1:0] rem_r, rem_nxt;
  logic [NUM_W-1:0] den_r, den_nxt;
  logic [PCT_W-1:0] quo_r, quo_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             done_r, done_nxt;
  logic             fit;

  // one restoring step per cycle, divisor walks down from bit 6
  assign fit = (rem_r >= den_r);

  always_comb begin
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    quo_nxt  = quo_r;
    cnt_nxt  = cnt_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt = num;
      den_nxt = {1'b0, den, 6'b0};
      cnt_nxt = DIV_STEPS;
    end else if (cnt_r != '0) begin
      if (fit) begin
        rem_nxt = rem_r - den_r;
      end
      quo_nxt  = {quo_r[PCT_W-2:0], fit};
      den_nxt  = den_r >> 1;
      cnt_nxt  = cnt_r - 3'd1;
      done_nxt = (cnt_r == 3'd1);
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    quo_r <= quo_nxt;
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
  end

  assign sts.busy = (cnt_r != '0);
  assign sts.done = done_r;
  assign quo      = quo_r;

endmodule

`default_nettype wire

// File: rtl/core/sensor_range_scaler_deadband.sv
// Channel  | Dir | Ports                               | Item
// in       | in  | in_tvalid/in_tready/in_tdata/tuser  | action, channel, raw reading
// out      | out | out_tvalid/out_tready/out_tdata     | channel, level, flags, limits
// cfg      | in  | cfg_valid/cfg_ready/cfg_data        | deadband
//
// Measure on a good span: accept, load, range check, 7 divider steps, quotient capture,
// write-back; below low limit or above full scale the divider is skipped. Every other
// item goes from load to write-back. One item at a time; in_tready is low meanwhile.
// Synchronous active-low reset restores limits, levels and deadband.
// A stalled result holds in the output register; the next item may be taken meanwhile.
`default_nettype none

module sensor_range_scaler_deadband #(
  parameter int CHANNELS = srsd_pkg::CHANNELS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  // [1:0] channel, [11:2] raw_reading, [15:12] zero
  input  wire logic [srsd_pkg::IN_DATA_W-1:0]    in_tdata,
  // [1:0] action
  input  wire logic [srsd_pkg::IN_USER_W-1:0]    in_tuser,
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  // [1:0] out_channel, [8:2] level, [9] level_changed, [10] clipped,
  // [11] span_bad, [19:12] low_out, [27:20] high_out, [31:28] zero
  output logic      [srsd_pkg::OUT_DATA_W-1:0]   out_tdata,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [srsd_pkg::PCT_W-1:0]        cfg_data
);
  import srsd_pkg::*;

  localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_LOAD  = 5'b00010,
    ST_CHECK = 5'b00100,
    ST_DIV   = 5'b01000,
    ST_FIN   = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  logic [ACT_W-1:0] act_r;
  logic [CH_W-1:0]  ch_r;
  logic [RD_W-1:0]  rd_r;
  logic             rng_r;
  logic             bad_r;
  logic             neg_r;
  logic             clip_r;
  logic [LIM_W-1:0] diff_r;
  logic [LIM_W-1:0] span_r;
  logic [PCT_W-1:0] val_r;
  logic [PCT_W-1:0] deadband_r;

  logic [LIM_W-1:0] low_r  [CHANNELS];
  logic [LIM_W-1:0] high_r [CHANNELS];
  logic [PCT_W-1:0] kept_r [CHANNELS];

  logic                  out_tvalid_r;
  logic [OUT_DATA_W-1:0] out_tdata_r, out_tdata_nxt;

  logic             in_acc;
  logic             in_rng;
  logic [3:0]       ch_ext;
  logic [IDX_W-1:0] idx;
  logic [LIM_W-1:0] lo_cur, hi_cur;
  logic [PCT_W-1:0] kept_cur;
  logic [NUM_W-1:0] num;
  logic             over;
  logic             div_start;
  div_sts_t         div_sts;
  logic [PCT_W-1:0] div_quo;
  logic             fin_go;
  logic [LIM_W-1:0] lo_new, hi_new;
  logic [PCT_W:0]   k_hi, v_hi;
  logic             chg;
  logic [PCT_W-1:0] lvl_new;

  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  assign in_rng = (int'(ch_r) < CHANNELS);
  assign ch_ext = {2'b0, ch_r};
  assign idx    = in_rng ? ch_ext[IDX_W-1:0] : '0;

  assign lo_cur   = low_r[idx];
  assign hi_cur   = high_r[idx];
  assign kept_cur = kept_r[idx];

  assign num       = NUM_W'(diff_r) * MUL_PCT;
  assign over      = (num >= NUM_W'(span_r) * MUL_OVER);
  assign div_start = (state_r == ST_CHECK) && !neg_r && !over;

  srsd_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (num),
    .den   (span_r),
    .sts   (div_sts),
    .quo   (div_quo)
  );

  assign fin_go = (state_r == ST_FIN) && !(out_tvalid_r && !out_tready);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:  if (in_acc) state_nxt = ST_LOAD;
      ST_LOAD: begin
        if (in_rng && act_r == ACT_MEASURE && hi_cur > lo_cur) begin
          state_nxt = ST_CHECK;
        end else begin
          state_nxt = ST_FIN;
        end
      end
      ST_CHECK: state_nxt = div_start ? ST_DIV : ST_FIN;
      ST_DIV:   if (div_sts.done) state_nxt = ST_FIN;
      ST_FIN:   if (fin_go) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // write-back values
  always_comb begin
    lo_new = lo_cur;
    hi_new = hi_cur;
    if (act_r == ACT_CAL_START) begin
      lo_new = LIM_TOP;
      hi_new = LIM_BOT;
    end else if (act_r == ACT_CAL_SAMPLE) begin
      if (rd_r > hi_cur) begin
        hi_new = rd_r;
      end else if (rd_r < lo_cur) begin
        lo_new = rd_r;
      end
    end
  end

  assign k_hi    = {1'b0, kept_cur} + {1'b0, deadband_r};
  assign v_hi    = {1'b0, val_r} + {1'b0, deadband_r};
  assign chg     = (act_r == ACT_MEASURE) && !bad_r &&
                   (({1'b0, val_r} > k_hi) || (v_hi < {1'b0, kept_cur}));
  assign lvl_new = chg ? val_r : kept_cur;

  always_comb begin
    out_tdata_nxt       = '0;
    out_tdata_nxt[1:0]  = ch_r;
    if (rng_r) begin
      out_tdata_nxt[8:2]   = lvl_new;
      out_tdata_nxt[9]     = chg;
      out_tdata_nxt[10]    = clip_r && (act_r == ACT_MEASURE);
      out_tdata_nxt[11]    = bad_r;
      out_tdata_nxt[19:12] = lo_new;
      out_tdata_nxt[27:20] = hi_new;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      act_r <= in_tuser[ACT_W-1:0];
      ch_r  <= in_tdata[CH_W-1:0];
      rd_r  <= in_tdata[CH_W+RAW_W-1:CH_W+RAW_W-RD_W];
    end
    if (state_r == ST_LOAD) begin
      rng_r  <= in_rng;
      bad_r  <= (act_r == ACT_MEASURE) && !(hi_cur > lo_cur);
      neg_r  <= (rd_r < lo_cur);
      diff_r <= (rd_r < lo_cur) ? (lo_cur - rd_r) : (rd_r - lo_cur);
      span_r <= hi_cur - lo_cur;
      clip_r <= 1'b0;
      val_r  <= '0;
    end
    if (state_r == ST_CHECK) begin
      if (neg_r) begin
        clip_r <= (num >= NUM_W'(span_r));
      end else if (over) begin
        clip_r <= 1'b1;
        val_r  <= PCT_FULL;
      end
    end
    if (state_r == ST_DIV && div_sts.done) begin
      val_r <= div_quo;
    end
    if (fin_go) begin
      out_tdata_r <= out_tdata_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      out_tvalid_r <= 1'b0;
      deadband_r   <= DEADBAND_RST;
      for (int i = 0; i < CHANNELS; i++) begin
        low_r[i]  <= LIM_BOT;
        high_r[i] <= LIM_TOP;
        kept_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      if (fin_go) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        deadband_r <= cfg_data;
      end
      if (fin_go && rng_r) begin
        if (act_r == ACT_CAL_START) begin
          for (int i = 0; i < CHANNELS; i++) begin
            low_r[i]  <= LIM_TOP;
            high_r[i] <= LIM_BOT;
          end
        end else begin
          low_r[idx]  <= lo_new;
          high_r[idx] <= hi_new;
          kept_r[idx] <= lvl_new;
        end
      end
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

endmodule

`default_nettype wire

// File: rtl/core/srsd_chk.sv
`default_nettype none

module srsd_chk (
  input wire logic                              clk,
  input wire logic                              rst_n,
  input wire logic                              in_tvalid,
  input wire logic                              in_tready,
  input wire logic                              out_tvalid,
  input wire logic                              out_tready,
  input wire logic [srsd_pkg::OUT_DATA_W-1:0]   out_tdata
);
  import srsd_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("item taken while busy");

  a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[8:2] <= PCT_FULL)
    else $error("level above full scale");

  a_bad_span_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[11] |-> !out_tdata[9] && !out_tdata[10])
    else $error("bad span with level change or clip");

endmodule

bind sensor_range_scaler_deadband srsd_chk u_srsd_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

`default_nettype wire
